[src/kemt_pkg.sv]
// Shared types and constants for the keyed entity map table.
package kemt_pkg;

    localparam int KeyWidth          = 32;
    localparam int DataWidth         = 32;
    localparam int CapWidth          = 7;
    localparam int CountWidth        = 7;
    localparam int ApbAddrWidth      = 3;
    localparam int ApbDataWidth      = 32;
    localparam int DefaultDepth      = 64;
    localparam int DefaultValueWidth = 32;
    localparam int MaxEntries        = 2 ** CapWidth - 1;

    localparam logic [CapWidth-1:0] CapReset = 7'd64;

    // Register index, taken from paddr[2]
    localparam logic RegCapacity = 1'b0;

    typedef logic [1:0] op_t;
    localparam op_t OpCreate  = 2'd0;
    localparam op_t OpLookup  = 2'd1;
    localparam op_t OpDestroy = 2'd2;

    typedef enum logic [1:0] {
        StOk   = 2'd0,
        StDup  = 2'd1,
        StFull = 2'd2,
        StMiss = 2'd3
    } status_t;

    typedef struct packed {
        logic                  done;
        status_t               status;
        logic [DataWidth-1:0]  found_value;
        logic [CountWidth-1:0] live_count;
    } result_t;

endpackage

[src/kemt_ram.sv]
// Single-port-write, registered-read table memory.
module kemt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[src/kemt_seq.sv]
// Scan sequencer: one table entry compared per cycle, then a single update step.
module kemt_seq #(
    parameter int DEPTH       = kemt_pkg::DefaultDepth,
    parameter int VALUE_WIDTH = kemt_pkg::DefaultValueWidth
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  kemt_pkg::op_t                     op,
    input  logic [kemt_pkg::KeyWidth-1:0]     search_key,
    input  logic [kemt_pkg::DataWidth-1:0]    new_value,
    input  logic [kemt_pkg::CapWidth-1:0]     capacity,
    output logic                              busy,
    output kemt_pkg::result_t                 result
);

    import kemt_pkg::*;

    localparam int UsedDepth  = (DEPTH < MaxEntries) ? DEPTH : MaxEntries;
    localparam int AddrWidth  = $clog2(UsedDepth);
    localparam int EntryWidth = KeyWidth + VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic                    more_reg;
    logic                    pend_reg;
    logic                    hit_reg;
    logic                    free_found_reg;
    logic [AddrWidth-1:0]    addr_reg;
    logic [AddrWidth-1:0]    last_reg;
    logic [UsedDepth-1:0]    valid_reg;
    logic [CountWidth-1:0]   count_reg;
    logic                    done_reg;
    status_t                 status_reg;
    logic [DataWidth-1:0]    found_reg;
    logic [CountWidth-1:0]   live_reg;

    op_t                     op_reg;
    logic [KeyWidth-1:0]     key_reg;
    logic [VALUE_WIDTH-1:0]  val_reg;
    logic [AddrWidth-1:0]    idx_d_reg;
    logic                    vld_d_reg;
    logic [AddrWidth-1:0]    hit_idx_reg;
    logic [VALUE_WIDTH-1:0]  hit_val_reg;
    logic [AddrWidth-1:0]    free_idx_reg;

    logic [CapWidth-1:0]     limit;
    logic [CapWidth-1:0]     limit_last;
    logic                    accept;
    logic                    ram_we;
    logic [EntryWidth-1:0]   ram_rdata;
    logic [KeyWidth-1:0]     rd_key;
    logic [VALUE_WIDTH-1:0]  rd_val;
    logic                    match;
    logic                    free_here;
    logic                    last_data;
    status_t                 fin_status;
    logic [DataWidth-1:0]    fin_found;
    logic [CountWidth-1:0]   count_after;
    logic                    set_valid;
    logic                    clr_valid;

    assign limit      = (capacity > CapWidth'(UsedDepth)) ? CapWidth'(UsedDepth) : capacity;
    assign limit_last = limit - 1'b1;
    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);

    assign ram_we = (state_reg == S_FINISH) && (op_reg == OpCreate) && !hit_reg
                    && free_found_reg;

    kemt_ram #(
        .WIDTH (EntryWidth),
        .DEPTH (UsedDepth)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({val_reg, key_reg}),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[KeyWidth-1:0];
    assign rd_val = ram_rdata[EntryWidth-1:KeyWidth];

    // Compare stage works on the entry read in the previous cycle
    assign match     = (state_reg == S_SCAN) && pend_reg && vld_d_reg && (rd_key == key_reg);
    assign free_here = (state_reg == S_SCAN) && pend_reg && !vld_d_reg && !free_found_reg;
    assign last_data = pend_reg && (idx_d_reg == last_reg);

    always_comb
    begin
        fin_status  = StMiss;
        fin_found   = '0;
        count_after = count_reg;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        unique case (op_reg)
            OpCreate:
            begin
                if (hit_reg)
                begin
                    fin_status = StDup;
                end
                else if (free_found_reg)
                begin
                    fin_status  = StOk;
                    set_valid   = 1'b1;
                    count_after = count_reg + 1'b1;
                end
                else
                begin
                    fin_status = StFull;
                end
            end
            OpLookup:
            begin
                if (hit_reg)
                begin
                    fin_status = StOk;
                    fin_found  = DataWidth'(hit_val_reg);
                end
            end
            OpDestroy:
            begin
                if (hit_reg)
                begin
                    fin_status = StOk;
                    clr_valid  = 1'b1;
                    if (count_reg != '0)
                    begin
                        count_after = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                fin_status = StMiss;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            more_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            addr_reg       <= '0;
            last_reg       <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            status_reg     <= StOk;
            found_reg      <= '0;
            live_reg       <= '0;
        end
        else
        begin
            // Strobe the result in the cycle after the update step
            done_reg <= (state_reg == S_FINISH);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        pend_reg       <= 1'b0;
                        addr_reg       <= '0;
                        last_reg       <= limit_last[AddrWidth-1:0];
                        if (limit == '0)
                        begin
                            more_reg  <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            more_reg  <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Issue the next read while comparing the previous one
                    pend_reg <= more_reg;
                    if (more_reg)
                    begin
                        if (addr_reg == last_reg)
                        begin
                            more_reg <= 1'b0;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    if (free_here)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (match || last_data)
                    begin
                        hit_reg   <= match;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (set_valid)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                    if (clr_valid)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    count_reg  <= count_after;
                    status_reg <= fin_status;
                    found_reg  <= fin_found;
                    live_reg   <= count_after;
                    pend_reg   <= 1'b0;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= search_key;
            val_reg <= VALUE_WIDTH'(new_value);
        end
        idx_d_reg <= addr_reg;
        vld_d_reg <= valid_reg[addr_reg];
        if (match)
        begin
            hit_idx_reg <= idx_d_reg;
            hit_val_reg <= rd_val;
        end
        if (free_here)
        begin
            free_idx_reg <= idx_d_reg;
        end
    end

    assign result.done        = done_reg;
    assign result.status      = status_reg;
    assign result.found_value = found_reg;
    assign result.live_count  = live_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(UsedDepth))
        else $error("live count beyond table depth");

    a_create_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == StDup || status_reg == StFull) |-> op_reg == OpCreate)
        else $error("duplicate or full reported for a non-create request");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (found_reg != '0) |-> status_reg == StOk)
        else $error("value returned on a failed request");
`endif

endmodule

[src/keyed_entity_map_table.sv]
// Keyed entity map table: a request is taken when start is high and busy is low, and
// its result appears for one cycle with done high; the receiver cannot stall it.
// A request scans the first min(capacity_in_use, DEPTH) table entries before done
// (none when capacity_in_use is zero), fewer when a matching key is found early:
// the table memory is read one entry per cycle and the duplicate check and free-slot
// search share that single pass. busy is low in the done cycle, so the next request
// may follow at once. The user writes capacity_in_use over the APB port at byte address
// 0 only while no request is in flight; the block itself does not enforce this.
module keyed_entity_map_table #(
    parameter int DEPTH       = kemt_pkg::DefaultDepth,
    parameter int VALUE_WIDTH = kemt_pkg::DefaultValueWidth
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kemt_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [kemt_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [kemt_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                pready,
    input  logic                                start,
    input  logic [1:0]                          op,
    input  logic [kemt_pkg::KeyWidth-1:0]       search_key,
    input  logic [kemt_pkg::DataWidth-1:0]      new_value,
    output logic                                busy,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [kemt_pkg::DataWidth-1:0]      found_value,
    output logic [kemt_pkg::CountWidth-1:0]     live_count
);

    import kemt_pkg::*;

    logic [CapWidth-1:0] cap_reg;
    logic                cfg_wr;
    result_t             result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CapReset;
        end
        else if (cfg_wr && (paddr[2] == RegCapacity))
        begin
            cap_reg <= pwdata[CapWidth-1:0];
        end
    end

    assign prdata = (paddr[2] == RegCapacity) ? ApbDataWidth'(cap_reg) : '0;

    kemt_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op_t'(op)),
        .search_key (search_key),
        .new_value  (new_value),
        .capacity   (cap_reg),
        .busy       (busy),
        .result     (result)
    );

    assign done        = result.done;
    assign status      = result.status;
    assign found_value = result.found_value;
    assign live_count  = result.live_count;

endmodule
